[design/battery_temp_aging_histogram_core_assert.svh]
// Assertion macros shared by the checker of the battery temperature aging histogram.
`ifndef BATTERY_TEMP_AGING_HISTOGRAM_CORE_ASSERT_SVH
`define BATTERY_TEMP_AGING_HISTOGRAM_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTAH_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BTAH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/btah_pkg.sv]
// Shared constants, types and register indexes of the battery temperature aging histogram.
package btah_pkg;

   localparam int BUCKETS   = 5;
   localparam int BUCKET_W  = $clog2(BUCKETS);
   localparam int TIME_W    = 40;
   localparam int TEMP_W    = 12;
   localparam int LEVEL_W   = 7;
   localparam int CAP_W     = 32;
   localparam int DWELL_W   = 48;
   localparam int ACC_W     = 32;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int GAP_W     = 16;

   typedef logic signed [TEMP_W-1:0] temp_type;

   typedef struct packed {
      logic [CAP_W-1:0]   capacity;
      logic [DWELL_W-1:0] dwell;
      logic [TIME_W-1:0]  touch;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      temp_type hot;
      temp_type warm;
      temp_type mild;
      temp_type cold;
   } limits_type;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_GAP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOST     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOT       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WARM      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MILD      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COLD      = 3'd6;

   // Register values after reset.
   localparam logic [GAP_W-1:0] MAX_GAP_RST   = 16'd7200;
   localparam logic [GAP_W-1:0] THRESHOLD_RST = 16'd1800;
   localparam logic [GAP_W-1:0] BOOST_RST     = 16'd1800;
   localparam temp_type         HOT_RST       = 12'sd550;
   localparam temp_type         WARM_RST      = 12'sd449;
   localparam temp_type         MILD_RST      = 12'sd100;
   localparam temp_type         COLD_RST      = -12'sd50;

   // Bucket codes, hottest first.
   localparam logic [BUCKET_W-1:0] BKT_HOT  = 3'd0;
   localparam logic [BUCKET_W-1:0] BKT_WARM = 3'd1;
   localparam logic [BUCKET_W-1:0] BKT_MILD = 3'd2;
   localparam logic [BUCKET_W-1:0] BKT_COOL = 3'd3;
   localparam logic [BUCKET_W-1:0] BKT_COLD = 3'd4;
   localparam logic [BUCKET_W-1:0] BKT_LAST = BUCKET_W'(BUCKETS - 1);

endpackage

[design/btah_req_if.sv]
// Sample channel carrying one battery sample per beat.
interface btah_req_if;
   import btah_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [TIME_W-1:0]         now_seconds;
   logic signed [TEMP_W-1:0]  temperature_tenths;
   logic [LEVEL_W-1:0]        battery_level;
   logic                      ac_online;
   logic                      usb_online;
   logic                      wireless_online;
   logic                      dock_online;

   modport source (
      output valid, now_seconds, temperature_tenths, battery_level,
             ac_online, usb_online, wireless_online, dock_online,
      input  ready
   );

   modport sink (
      input  valid, now_seconds, temperature_tenths, battery_level,
             ac_online, usb_online, wireless_online, dock_online,
      output ready
   );
endinterface

[design/btah_rsp_if.sv]
// Record channel carrying one bucket record per beat.
interface btah_rsp_if;
   import btah_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [BUCKET_W-1:0]  bucket_index;
   logic [CAP_W-1:0]     capacity_gained;
   logic [DWELL_W-1:0]   dwell_seconds;
   logic [TIME_W-1:0]    last_touch_time;
   logic [TIME_W-1:0]    flush_time;
   logic                 last;

   modport source (
      output valid, bucket_index, capacity_gained, dwell_seconds,
             last_touch_time, flush_time, last,
      input  ready
   );

   modport sink (
      input  valid, bucket_index, capacity_gained, dwell_seconds,
             last_touch_time, flush_time, last,
      output ready
   );
endinterface

[design/btah_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module btah_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[design/btah_classify.sv]
// Temperature to bucket classification against the four programmed limits.
module btah_classify (
   input  btah_pkg::temp_type            temperature,
   input  btah_pkg::limits_type          limits,
   output logic [btah_pkg::BUCKET_W-1:0] bucket
);
   import btah_pkg::*;

   // The limits are tested hottest first; the first that holds decides.
   always_comb begin
      priority if (temperature >= limits.hot) begin
         bucket = BKT_HOT;
      end else if (temperature > limits.warm) begin
         bucket = BKT_WARM;
      end else if (temperature >= limits.mild) begin
         bucket = BKT_MILD;
      end else if (temperature >= limits.cold) begin
         bucket = BKT_COOL;
      end else begin
         bucket = BKT_COLD;
      end
   end
endmodule

[design/battery_temp_aging_histogram_core.sv]
// Top level of the battery temperature aging histogram: sequencer, registers and bucket memory.
//
//   Channel   Direction  Payload per beat
//   req_chan  in         now_seconds, temperature_tenths, battery_level, four online flags
//   rsp_chan  out        bucket_index, capacity_gained, dwell_seconds, last_touch_time,
//                        flush_time, last
//   csr_*     in         csr_index, csr_wdata on csr_we (no read-back)
//
// A sample runs from its beat through the states that classify and read the bucket, write it
// back, add the boost and test the threshold, and then returns to idle, where the next beat
// is taken. A flush walks each bucket through three steps (read, load output register, hand
// over) and waits at the hand-over for as long as rsp_chan stalls.
// The single read and write port of the bucket memory sets this sequence.
// Reset is synchronous and active high; it clears the sequencer, the sample history,
// the accumulator and the per-bucket valid bits, so the memory needs no clearing pass.
// req_chan is ready only while no sample is in progress.
module battery_temp_aging_histogram_core (
   input  logic                            clock,
   input  logic                            reset,
   btah_req_if.sink                        req_chan,
   btah_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [btah_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [btah_pkg::CSR_W-1:0]      csr_wdata
);
   import btah_pkg::*;

   // Sequencer codes.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CALC  = 3'd1;
   localparam logic [2:0] ST_UPD   = 3'd2;
   localparam logic [2:0] ST_BOOST = 3'd3;
   localparam logic [2:0] ST_CHK   = 3'd4;
   localparam logic [2:0] ST_FRD   = 3'd5;
   localparam logic [2:0] ST_FLD   = 3'd6;
   localparam logic [2:0] ST_FOUT  = 3'd7;

   logic [2:0] state_ff, state_in;

   // Configuration registers.
   logic [GAP_W-1:0] max_gap_ff, threshold_ff, boost_ff;
   limits_type       limits_ff;

   // Captured sample.
   logic [TIME_W-1:0]  now_ff;
   temp_type           temp_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic               chg_ff;

   // History of the previous sample.
   logic               have_prev_ff, have_prev_in;
   logic [TIME_W-1:0]  prev_time_ff, prev_time_in;
   temp_type           prev_temp_ff, prev_temp_in;
   logic [LEVEL_W-1:0] prev_level_ff, prev_level_in;
   logic               prev_chg_ff, prev_chg_in;

   logic [ACC_W-1:0]   acc_ff, acc_in;

   // Results of the classify cycle.
   logic               credit_ff, credit_in;
   logic               consider_ff, consider_in;
   logic [GAP_W-1:0]   elapsed_ff, elapsed_in;
   logic [BUCKET_W-1:0] bucket_ff, bucket_in;
   logic [LEVEL_W-1:0] gain_ff, gain_in;
   logic               was_chg_ff, was_chg_in;
   logic               toggle_ff, toggle_in;

   // Flush walk and output register.
   logic [BUCKET_W-1:0] idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BUCKET_W-1:0] rsp_bucket_ff, rsp_bucket_in;
   entry_type           rsp_entry_ff, rsp_entry_in;
   logic [TIME_W-1:0]   rsp_flush_ff, rsp_flush_in;
   logic                rsp_last_ff, rsp_last_in;

   // Bucket memory and its valid bits; an entry never written reads as zero.
   logic [BUCKETS-1:0]  valid_ff, valid_in;
   logic [BUCKET_W-1:0] rd_addr_ff, rd_addr;
   logic                ram_we;
   logic [BUCKET_W-1:0] ram_waddr;
   entry_type           ram_wdata;
   logic [ENTRY_W-1:0]  ram_rdata;
   entry_type           entry_rd;

   logic [BUCKET_W-1:0] prev_bucket;
   logic                req_beat;
   logic                rsp_beat;

   logic [TIME_W:0]     diff;
   logic                in_range;
   logic [DWELL_W:0]    dwell_sum;
   logic [CAP_W:0]      cap_sum;
   logic [ACC_W:0]      acc_sum_elapsed;
   logic [ACC_W:0]      acc_sum_boost;
   entry_type           upd_entry;

   btah_classify u_classify (
      .temperature (prev_temp_ff),
      .limits      (limits_ff),
      .bucket      (prev_bucket)
   );

   btah_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (BUCKETS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   assign req_beat = req_chan.valid && req_chan.ready;
   assign rsp_beat = rsp_chan.valid && rsp_chan.ready;

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.bucket_index  = rsp_bucket_ff;
   assign rsp_chan.capacity_gained = rsp_entry_ff.capacity;
   assign rsp_chan.dwell_seconds = rsp_entry_ff.dwell;
   assign rsp_chan.last_touch_time = rsp_entry_ff.touch;
   assign rsp_chan.flush_time    = rsp_flush_ff;
   assign rsp_chan.last          = rsp_last_ff;

   // The memory read issues in the classify cycle for the credited bucket and in the
   // read cycle of a flush for the walked bucket.
   assign rd_addr  = (state_ff == ST_CALC) ? prev_bucket : idx_ff;
   assign entry_rd = valid_ff[rd_addr_ff] ? entry_type'(ram_rdata) : '0;

   // Elapsed time with the borrow kept, so that a clock running backwards shows up.
   assign diff     = {1'b0, now_ff} - {1'b0, prev_time_ff};
   assign in_range = (diff[TIME_W-1:GAP_W] == '0) && (diff[GAP_W-1:0] <= max_gap_ff);

   // Saturating sums of the update cycle.
   assign dwell_sum = {1'b0, entry_rd.dwell} + (DWELL_W + 1)'(elapsed_ff);
   assign cap_sum   = {1'b0, entry_rd.capacity} + (CAP_W + 1)'(gain_ff);
   assign acc_sum_elapsed = {1'b0, acc_ff} + (ACC_W + 1)'(elapsed_ff);
   assign acc_sum_boost   = {1'b0, acc_ff} + (ACC_W + 1)'(boost_ff);

   always_comb begin
      upd_entry = entry_rd;
      if (!was_chg_ff) begin
         upd_entry.dwell = dwell_sum[DWELL_W] ? '1 : dwell_sum[DWELL_W-1:0];
      end else begin
         upd_entry.capacity = cap_sum[CAP_W] ? '1 : cap_sum[CAP_W-1:0];
      end
      upd_entry.touch = now_ff;
   end

   // Memory write: the credited bucket after its update, or a flushed bucket with its
   // capacity and dwell cleared and its last-touch time kept.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = bucket_ff;
      ram_wdata = upd_entry;
      if (state_ff == ST_UPD && credit_ff) begin
         ram_we = 1'b1;
      end else if (state_ff == ST_FLD) begin
         ram_we          = 1'b1;
         ram_waddr       = idx_ff;
         ram_wdata       = '0;
         ram_wdata.touch = entry_rd.touch;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ram_we) begin
         valid_in[ram_waddr] = 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      have_prev_in  = have_prev_ff;
      prev_time_in  = prev_time_ff;
      prev_temp_in  = prev_temp_ff;
      prev_level_in = prev_level_ff;
      prev_chg_in   = prev_chg_ff;
      acc_in        = acc_ff;
      credit_in     = credit_ff;
      consider_in   = consider_ff;
      elapsed_in    = elapsed_ff;
      bucket_in     = bucket_ff;
      gain_in       = gain_ff;
      was_chg_in    = was_chg_ff;
      toggle_in     = toggle_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_flush_in  = rsp_flush_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            // Credit only within an ordered, short enough gap; the first sample has
            // nothing to credit but may still flush.
            credit_in   = have_prev_ff && !diff[TIME_W] && in_range;
            consider_in = !have_prev_ff || (!diff[TIME_W] && in_range);
            elapsed_in  = diff[GAP_W-1:0];
            bucket_in   = prev_bucket;
            gain_in     = (level_ff > prev_level_ff) ? level_ff - prev_level_ff : '0;
            was_chg_in  = prev_chg_ff;
            toggle_in   = chg_ff ^ prev_chg_ff;
            // The history always takes the new sample, also on a skipped gap.
            have_prev_in  = 1'b1;
            prev_time_in  = now_ff;
            prev_temp_in  = temp_ff;
            prev_level_in = level_ff;
            prev_chg_in   = chg_ff;
            state_in      = ST_UPD;
         end
         ST_UPD: begin
            if (credit_ff) begin
               acc_in = acc_sum_elapsed[ACC_W] ? '1 : acc_sum_elapsed[ACC_W-1:0];
            end
            state_in = ST_BOOST;
         end
         ST_BOOST: begin
            if (credit_ff && toggle_ff) begin
               acc_in = acc_sum_boost[ACC_W] ? '1 : acc_sum_boost[ACC_W-1:0];
            end
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (consider_ff && (acc_ff >= ACC_W'(threshold_ff))) begin
               idx_in   = '0;
               state_in = ST_FRD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FRD: begin
            state_in = ST_FLD;
         end
         ST_FLD: begin
            rsp_valid_in  = 1'b1;
            rsp_bucket_in = idx_ff;
            rsp_entry_in  = entry_rd;
            rsp_flush_in  = now_ff;
            rsp_last_in   = (idx_ff == BKT_LAST);
            state_in      = ST_FOUT;
         end
         ST_FOUT: begin
            if (rsp_beat) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  acc_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_FRD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         have_prev_ff  <= 1'b0;
         prev_time_ff  <= '0;
         prev_temp_ff  <= '0;
         prev_level_ff <= '0;
         prev_chg_ff   <= 1'b0;
         acc_ff        <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         idx_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         have_prev_ff  <= have_prev_in;
         prev_time_ff  <= prev_time_in;
         prev_temp_ff  <= prev_temp_in;
         prev_level_ff <= prev_level_in;
         prev_chg_ff   <= prev_chg_in;
         acc_ff        <= acc_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         idx_ff        <= idx_in;
      end
   end

   // Configuration registers: the user writes them only while the block is idle; not enforced.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_gap_ff     <= MAX_GAP_RST;
         threshold_ff   <= THRESHOLD_RST;
         boost_ff       <= BOOST_RST;
         limits_ff.hot  <= HOT_RST;
         limits_ff.warm <= WARM_RST;
         limits_ff.mild <= MILD_RST;
         limits_ff.cold <= COLD_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_GAP:   max_gap_ff     <= csr_wdata;
            CSR_THRESHOLD: threshold_ff   <= csr_wdata;
            CSR_BOOST:     boost_ff       <= csr_wdata;
            CSR_HOT:       limits_ff.hot  <= csr_wdata[TEMP_W-1:0];
            CSR_WARM:      limits_ff.warm <= csr_wdata[TEMP_W-1:0];
            CSR_MILD:      limits_ff.mild <= csr_wdata[TEMP_W-1:0];
            CSR_COLD:      limits_ff.cold <= csr_wdata[TEMP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_beat) begin
         now_ff   <= req_chan.now_seconds;
         temp_ff  <= req_chan.temperature_tenths;
         level_ff <= req_chan.battery_level;
         chg_ff   <= req_chan.ac_online | req_chan.usb_online
                   | req_chan.wireless_online | req_chan.dock_online;
      end
      rd_addr_ff    <= rd_addr;
      credit_ff     <= credit_in;
      consider_ff   <= consider_in;
      elapsed_ff    <= elapsed_in;
      bucket_ff     <= bucket_in;
      gain_ff       <= gain_in;
      was_chg_ff    <= was_chg_in;
      toggle_ff     <= toggle_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_flush_ff  <= rsp_flush_in;
      rsp_last_ff   <= rsp_last_in;
   end
endmodule

[design/btah_checker.sv]
// Port-level checker of the battery temperature aging histogram and its bind.
module btah_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [btah_pkg::BUCKET_W-1:0] rsp_bucket_index,
   input logic                          rsp_last
);
   import btah_pkg::*;

`include "battery_temp_aging_histogram_core_assert.svh"

   // A sample occupies the block, so no second beat is taken straight after one.
   `BTAH_ASSERT_NEXT(a_one_sample, req_valid && req_ready, !req_ready, "sample overlap")

   // No sample is taken while records of a flush are on offer.
   `BTAH_ASSERT_NOW(a_no_req_in_flush, rsp_valid, !req_ready, "sample taken during flush")

   // The final record of a flush is the coldest bucket and only that one.
   `BTAH_ASSERT_NOW(a_last_bucket, rsp_valid, rsp_last == (rsp_bucket_index == BKT_LAST),
      "last flag does not match bucket")

   // After the final record the block returns to taking samples.
   `BTAH_ASSERT_NEXT(a_flush_end, rsp_valid && rsp_ready && rsp_last, req_ready,
      "not ready after flush")
endmodule

bind battery_temp_aging_histogram_core btah_checker u_btah_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_bucket_index (rsp_chan.bucket_index),
   .rsp_last         (rsp_chan.last)
);

[bench/btah_histogram_checker.sv]
// Checker for the battery temperature aging histogram: tracks registers, predicts records, compares.
module btah_histogram_checker (
   input  logic                           clock,
   input  logic                           reset,
   btah_req_if                            req_mon,
   btah_rsp_if                            rsp_mon,
   input  logic                           csr_we,
   input  logic [btah_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [btah_pkg::CSR_W-1:0]     csr_wdata,
   output int                             failures,
   output int                             outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import btah_pkg::*;

   localparam logic [63:0] CAP_MAX   = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] DWELL_MAX = 64'h0000_FFFF_FFFF_FFFF;
   localparam logic [63:0] ACC_MAX   = 64'h0000_0000_FFFF_FFFF;

   typedef struct packed {
      logic [BUCKET_W-1:0] bucket;
      logic [CAP_W-1:0]    capacity;
      logic [DWELL_W-1:0]  dwell;
      logic [TIME_W-1:0]   touch;
      logic [TIME_W-1:0]   flush;
      logic                last;
   } bucket_record_type;

   // Register copies.
   logic [GAP_W-1:0] max_gap;
   logic [GAP_W-1:0] threshold;
   logic [GAP_W-1:0] boost;
   limits_type       limits;

   // Sample history and histogram contents.
   logic                 seen_sample;
   logic [TIME_W-1:0]    prev_time;
   temp_type             prev_temp;
   logic [LEVEL_W-1:0]   prev_level;
   logic                 prev_charging;
   logic [ACC_W-1:0]     acc_time;
   logic [CAP_W-1:0]     bucket_cap   [BUCKETS];
   logic [DWELL_W-1:0]   bucket_dwell [BUCKETS];
   logic [TIME_W-1:0]    bucket_touch [BUCKETS];

   bucket_record_type bucket_records [$];

   logic [TIME_W-1:0]    elapsed;
   logic [BUCKET_W-1:0]  bkt;
   logic                 charging;
   logic                 counted;
   bucket_record_type    record;

   function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] max);
      logic [63:0] s;
      s = a + b;
      return (s > max) ? max : s;
   endfunction

   task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         max_gap       = MAX_GAP_RST;
         threshold     = THRESHOLD_RST;
         boost         = BOOST_RST;
         limits        = '{hot: HOT_RST, warm: WARM_RST, mild: MILD_RST, cold: COLD_RST};
         seen_sample   = 1'b0;
         prev_time     = '0;
         prev_temp     = '0;
         prev_level    = '0;
         prev_charging = 1'b0;
         acc_time      = '0;
         for (int i = 0; i < BUCKETS; i++) begin
            bucket_cap[i]   = '0;
            bucket_dwell[i] = '0;
            bucket_touch[i] = '0;
         end
         bucket_records.delete();
         outstanding <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (bucket_records.size() == 0) begin
               $error("bucket record %0d arrived with nothing expected", rsp_mon.bucket_index);
               failures++;
            end else begin
               record = bucket_records.pop_front();
               check_field("bucket_index", 64'(record.bucket), 64'(rsp_mon.bucket_index));
               check_field("capacity_gained", 64'(record.capacity),
                           64'(rsp_mon.capacity_gained));
               check_field("dwell_seconds", 64'(record.dwell), 64'(rsp_mon.dwell_seconds));
               check_field("last_touch_time", 64'(record.touch), 64'(rsp_mon.last_touch_time));
               check_field("flush_time", 64'(record.flush), 64'(rsp_mon.flush_time));
               check_field("last", 64'(record.last), 64'(rsp_mon.last));
            end
         end

         if (csr_we) begin
            case (csr_index)
               CSR_MAX_GAP:   max_gap     = csr_wdata;
               CSR_THRESHOLD: threshold   = csr_wdata;
               CSR_BOOST:     boost       = csr_wdata;
               CSR_HOT:       limits.hot  = temp_type'(csr_wdata[TEMP_W-1:0]);
               CSR_WARM:      limits.warm = temp_type'(csr_wdata[TEMP_W-1:0]);
               CSR_MILD:      limits.mild = temp_type'(csr_wdata[TEMP_W-1:0]);
               CSR_COLD:      limits.cold = temp_type'(csr_wdata[TEMP_W-1:0]);
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready) begin : age_buckets
            charging = req_mon.ac_online | req_mon.usb_online |
                       req_mon.wireless_online | req_mon.dock_online;
            counted  = 1'b1;
            if (seen_sample) begin
               elapsed = req_mon.now_seconds - prev_time;
               if (req_mon.now_seconds < prev_time || elapsed > TIME_W'(max_gap)) begin
                  counted = 1'b0;
               end else begin
                  // The interval belongs to the bucket of the previous temperature.
                  if ($signed(prev_temp) >= $signed(limits.hot))
                     bkt = BKT_HOT;
                  else if ($signed(prev_temp) > $signed(limits.warm))
                     bkt = BKT_WARM;
                  else if ($signed(prev_temp) >= $signed(limits.mild))
                     bkt = BKT_MILD;
                  else if ($signed(prev_temp) >= $signed(limits.cold))
                     bkt = BKT_COOL;
                  else
                     bkt = BKT_COLD;
                  if (!prev_charging)
                     bucket_dwell[bkt] = DWELL_W'(sat_add(64'(bucket_dwell[bkt]), 64'(elapsed),
                                                          DWELL_MAX));
                  else if (req_mon.battery_level > prev_level)
                     bucket_cap[bkt] = CAP_W'(sat_add(64'(bucket_cap[bkt]),
                                                      64'(req_mon.battery_level - prev_level),
                                                      CAP_MAX));
                  bucket_touch[bkt] = req_mon.now_seconds;
                  acc_time = ACC_W'(sat_add(64'(acc_time), 64'(elapsed), ACC_MAX));
                  if (charging != prev_charging)
                     acc_time = ACC_W'(sat_add(64'(acc_time), 64'(boost), ACC_MAX));
               end
            end

            if (counted && acc_time >= ACC_W'(threshold)) begin
               for (int i = 0; i < BUCKETS; i++) begin
                  record.bucket   = BUCKET_W'(i);
                  record.capacity = bucket_cap[i];
                  record.dwell    = bucket_dwell[i];
                  record.touch    = bucket_touch[i];
                  record.flush    = req_mon.now_seconds;
                  record.last     = (i == BUCKETS - 1);
                  bucket_records.push_back(record);
                  bucket_cap[i]   = '0;
                  bucket_dwell[i] = '0;
               end
               acc_time = '0;
            end

            prev_time     = req_mon.now_seconds;
            prev_temp     = req_mon.temperature_tenths;
            prev_level    = req_mon.battery_level;
            prev_charging = charging;
            seen_sample   = 1'b1;
         end

         outstanding <= bucket_records.size();
      end
   end

endmodule

[bench/tb_battery_temp_aging_histogram_core.sv]
// Testbench top of the battery temperature aging histogram: clock, reset, stimulus and verdict.
module tb_battery_temp_aging_histogram_core;
   timeunit 1ns;
   timeprecision 1ps;
   import btah_pkg::*;

   // Charger flags of a sample, packed as {ac, usb, wireless, dock}.
   localparam logic [3:0] ON_NONE     = 4'b0000;
   localparam logic [3:0] ON_AC       = 4'b1000;
   localparam logic [3:0] ON_USB      = 4'b0100;
   localparam logic [3:0] ON_WIRELESS = 4'b0010;
   localparam logic [3:0] ON_DOCK     = 4'b0001;
   localparam logic [3:0] ON_ALL      = 4'b1111;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam temp_type          TEMP_MIN = temp_type'(-2048);
   localparam temp_type          TEMP_MAX = temp_type'(2047);

   // Settling time that lets a sample still in flight, one that makes no record, run to its end.
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 64;

   typedef struct packed {
      logic [TIME_W-1:0]  now;
      temp_type           temp;
      logic [LEVEL_W-1:0] level;
      logic [3:0]         online;
   } battery_sample_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   int                   failures;
   int                   outstanding;

   // Idling percentages of the current phase, and the gap limit that steers the timestamps.
   int                   sender_idle_pct;
   int                   receiver_stall_pct;
   logic [GAP_W-1:0]     gap_now;

   btah_req_if req_chan ();
   btah_rsp_if rsp_chan ();

   battery_temp_aging_histogram_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   btah_histogram_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The run is cut short here if the block hangs; this is far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // The record sink decides ready afresh on every edge, following the phase's stall rate.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   function automatic battery_sample_type sample_of(logic [TIME_W-1:0] t, int temp, int lvl,
                                                    logic [3:0] online);
      battery_sample_type s;
      s.now    = t;
      s.temp   = temp_type'(temp);
      s.level  = LEVEL_W'(lvl);
      s.online = online;
      return s;
   endfunction

   // One register write per edge. The caller lowers the write enable after the last one, so
   // that back-to-back writes never lower and raise it within the same step.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Writes every register. Only called while the block is idle.
   task automatic apply_settings(logic [GAP_W-1:0] gap, logic [GAP_W-1:0] thr,
                                 logic [GAP_W-1:0] bst, temp_type hot, temp_type warm,
                                 temp_type mild, temp_type cold);
      write_reg(CSR_MAX_GAP,   gap);
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_BOOST,     bst);
      write_reg(CSR_HOT,       CSR_W'(hot));
      write_reg(CSR_WARM,      CSR_W'(warm));
      write_reg(CSR_MILD,      CSR_W'(mild));
      write_reg(CSR_COLD,      CSR_W'(cold));
      csr_we  <= 1'b0;
      gap_now  = gap;
      @(posedge clock);
   endtask

   // Presents one sample and returns at the edge where its beat is taken. Valid stays high
   // after the beat, so a sample that follows at once keeps it high without a glitch; it is
   // only lowered when the sender decides to idle.
   task automatic send_sample(battery_sample_type s);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid              <= 1'b1;
      req_chan.now_seconds        <= s.now;
      req_chan.temperature_tenths <= s.temp;
      req_chan.battery_level      <= s.level;
      req_chan.ac_online          <= s.online[3];
      req_chan.usb_online         <= s.online[2];
      req_chan.wireless_online    <= s.online[1];
      req_chan.dock_online        <= s.online[0];
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Holds the sender back until every predicted record has arrived, then lets a last sample
   // that makes no record run to its end. The checker's count is read only after a further edge,
   // so the beat just taken is already reflected in it.
   task automatic wait_histogram_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      battery_sample_type smp;
      logic [TIME_W-1:0] cursor;
      logic [TIME_W:0]   wide;
      int                level_now;
      logic              charging_now;
      int                pick;
      int                back;
      logic [GAP_W-1:0]  s_gap;
      logic [GAP_W-1:0]  s_thr;
      logic [GAP_W-1:0]  s_boost;
      temp_type          s_hot;
      temp_type          s_warm;
      temp_type          s_mild;
      temp_type          s_cold;

      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      gap_now            = MAX_GAP_RST;

      reset                       <= 1'b1;
      csr_we                      <= 1'b0;
      csr_index                   <= '0;
      csr_wdata                   <= '0;
      req_chan.valid              <= 1'b0;
      req_chan.now_seconds        <= '0;
      req_chan.temperature_tenths <= '0;
      req_chan.battery_level      <= '0;
      req_chan.ac_online          <= 1'b0;
      req_chan.usb_online         <= 1'b0;
      req_chan.wireless_online    <= 1'b0;
      req_chan.dock_online        <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With a threshold of zero the very first sample already flushes, with nothing yet
      // credited and every last-touch time still zero. The two samples after it flush too.
      apply_settings(MAX_GAP_RST, 16'd0, BOOST_RST, HOT_RST, WARM_RST, MILD_RST, COLD_RST);
      send_sample(sample_of(0, 0, 0, ON_NONE));
      send_sample(sample_of(100, 2047, 127, ON_AC));
      send_sample(sample_of(160, -2048, 100, ON_USB));
      wait_histogram_idle();

      // Default registers. The first samples walk the temperature across every limit, with
      // charging and a level drop, a level rise and an unchanged level in turn.
      apply_settings(MAX_GAP_RST, THRESHOLD_RST, BOOST_RST, HOT_RST, WARM_RST, MILD_RST,
                     COLD_RST);
      send_sample(sample_of(400, -51, 20, ON_WIRELESS));
      send_sample(sample_of(1000, -50, 40, ON_DOCK));
      send_sample(sample_of(1600, 99, 40, ON_DOCK));
      // Charging stops here, so the boost pushes the accumulator over the threshold.
      send_sample(sample_of(1900, 100, 45, ON_NONE));
      // The clock runs backwards: nothing credited and no flush, but the sample is kept.
      send_sample(sample_of(1500, 449, 45, ON_NONE));
      // One second beyond the longest gap is skipped as well.
      send_sample(sample_of(8701, 450, 45, ON_NONE));
      // Exactly the longest gap still counts, and flushes.
      send_sample(sample_of(15901, 549, 50, ON_NONE));
      send_sample(sample_of(15902, 550, 0, ON_AC));
      // Top of the time range: a skipped gap first, then a zero elapsed time while charging.
      send_sample(sample_of(TIME_MAX, 0, 0, ON_AC));
      send_sample(sample_of(TIME_MAX, 0, 0, ON_ALL));
      send_sample(sample_of(5, 300, 60, ON_NONE));
      wait_histogram_idle();

      // Unordered limits: the hot limit is the highest and the warm limit the lowest, so the
      // first test that holds decides and the mild and cold limits are fully shadowed.
      apply_settings(16'hFFFF, 16'hFFFF, 16'd0, temp_type'(2000), temp_type'(-100),
                     temp_type'(1000), temp_type'(500));
      send_sample(sample_of(65540, 1500, 30, ON_NONE));
      send_sample(sample_of(65600, -150, 10, ON_NONE));
      send_sample(sample_of(65700, 700, 10, ON_USB));
      send_sample(sample_of(65800, 0, 90, ON_USB));
      wait_histogram_idle();

      cursor       = 40'd65800;
      level_now    = 50;
      charging_now = 1'b0;

      // Random phases. Each one writes a fresh set of registers, from the reset values through
      // both extremes to random and unordered limits, and runs under one of four idling patterns.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               s_gap = MAX_GAP_RST; s_thr = THRESHOLD_RST; s_boost = BOOST_RST;
               s_hot = HOT_RST; s_warm = WARM_RST; s_mild = MILD_RST; s_cold = COLD_RST;
            end
            1: begin
               s_gap = '1; s_thr = '1; s_boost = '1;
               s_hot = TEMP_MAX; s_warm = TEMP_MAX; s_mild = TEMP_MAX; s_cold = TEMP_MAX;
            end
            2: begin
               s_gap = '0; s_thr = '0; s_boost = '0;
               s_hot = TEMP_MIN; s_warm = TEMP_MIN; s_mild = TEMP_MIN; s_cold = TEMP_MIN;
            end
            3: begin
               s_gap   = GAP_W'($urandom_range(1000, 20000));
               s_thr   = GAP_W'($urandom_range(500, 8000));
               s_boost = GAP_W'($urandom_range(0, 4000));
               s_hot   = temp_type'($urandom_range(0, 4095));
               s_warm  = temp_type'($urandom_range(0, 4095));
               s_mild  = temp_type'($urandom_range(0, 4095));
               s_cold  = temp_type'($urandom_range(0, 4095));
            end
            5: begin
               s_gap   = GAP_W'($urandom);
               s_thr   = GAP_W'($urandom);
               s_boost = GAP_W'($urandom);
               s_hot   = temp_type'($urandom_range(0, 4095));
               s_warm  = temp_type'($urandom_range(0, 4095));
               s_mild  = temp_type'($urandom_range(0, 4095));
               s_cold  = temp_type'($urandom_range(0, 4095));
            end
            6: begin
               s_gap = '1; s_thr = 16'd1; s_boost = '1;
               s_hot = HOT_RST; s_warm = WARM_RST; s_mild = MILD_RST; s_cold = COLD_RST;
            end
            default: begin
               // Limits scattered around the realistic temperature range, ordered but for warm, which may exceed hot.
               s_gap   = GAP_W'($urandom_range(3000, 10000));
               s_thr   = GAP_W'($urandom_range(1000, 6000));
               s_boost = GAP_W'($urandom_range(0, 2000));
               s_hot   = temp_type'($urandom_range(400, 700));
               s_warm  = temp_type'($urandom_range(300, 450));
               s_mild  = temp_type'($urandom_range(0, 200));
               s_cold  = temp_type'(int'($urandom_range(0, 199)) - 200);
            end
         endcase
         apply_settings(s_gap, s_thr, s_boost, s_hot, s_warm, s_mild, s_cold);

         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
            default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
         endcase

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
               // Noise: every field anywhere in its range.
               smp.now    = TIME_W'({$urandom, $urandom});
               smp.temp   = temp_type'($urandom_range(0, 4095));
               smp.level  = LEVEL_W'($urandom_range(0, 127));
               smp.online = 4'($urandom_range(0, 15));
            end else begin
               // A plausible monitor trace: mostly gaps within the limit, now and then a
               // repeated timestamp, a clock step backwards or a gap that is too long.
               if (pick < 12) begin
                  back = $urandom_range(1, 5000);
                  wide = (cursor >= TIME_W'(back)) ? {1'b0, cursor} - back : '0;
               end else if (pick < 20)
                  wide = {1'b0, cursor} + gap_now + 1 + $urandom_range(0, 50000);
               else if (pick < 30)
                  wide = {1'b0, cursor};
               else
                  wide = {1'b0, cursor} + $urandom_range(0, gap_now);
               smp.now = wide[TIME_W] ? TIME_MAX : wide[TIME_W-1:0];

               if ($urandom_range(99) < 12)
                  charging_now = !charging_now;
               smp.online = charging_now ? 4'($urandom_range(1, 15)) : ON_NONE;

               level_now = level_now + int'($urandom_range(0, 8)) - 3;
               if (level_now < 0)
                  level_now = 0;
               if (level_now > 100)
                  level_now = 100;
               smp.level = ($urandom_range(99) < 10) ? LEVEL_W'($urandom_range(101, 127))
                                                     : LEVEL_W'(level_now);
               smp.temp  = ($urandom_range(99) < 25)
                           ? temp_type'($urandom_range(0, 4095))
                           : temp_type'(int'($urandom_range(0, 1100)) - 300);
            end
            cursor = smp.now;
            send_sample(smp);
         end
         wait_histogram_idle();
      end

      if (failures == 0 && outstanding == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
